// File: rtl/tcs_pkg.sv
// Shared constants and types for the text console scrollback block.
`timescale 1ns / 1ps
package tcs_pkg;

    // Store geometry.
    localparam int HISTORY_LINES = 1024;
    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int LINE_W        = 10;
    localparam int TOTAL_W       = 11;
    localparam int COL_W         = 7;
    localparam int ROW_W         = 5;
    localparam int CELL_W        = 16;
    localparam int ADDR_W        = LINE_W + COL_W;
    localparam int TAB_STOP      = 4;

    // Character codes handled by put char.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;
    localparam logic [7:0] CH_MASK  = 8'h7F;
    localparam logic [7:0] COLOR_RESET = 8'd15;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_PGUP  = 3'd1,
        OP_PGDN  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLANK,
        ST_TAB,
        ST_READ,
        ST_OUT
    } state_t;

    // Cursor and viewport state seen by the view calculator.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [LINE_W-1:0]  wline;
        logic [COL_W-1:0]   wcol;
        logic [LINE_W-1:0]  vback;
    } cursor_t;

    // Screen placement derived from the cursor state.
    typedef struct packed {
        logic [LINE_W-1:0] start;
        logic [ROW_W-1:0]  crow;
        logic [COL_W-1:0]  ccol;
    } view_t;

endpackage

// File: rtl/tcs_cell_ram.sv
// Single write port, single registered read port cell memory.
`timescale 1ns / 1ps
module tcs_cell_ram #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tcs_view_calc.sv
// Viewport start line and on-screen cursor position.
`timescale 1ns / 1ps
module tcs_view_calc (
    input  tcs_pkg::cursor_t cur,
    output tcs_pkg::view_t   view
);

    logic [tcs_pkg::TOTAL_W-1:0] top_sum;
    logic [tcs_pkg::TOTAL_W-1:0] start_w;
    logic [tcs_pkg::TOTAL_W-1:0] end_w;
    logic [tcs_pkg::TOTAL_W-1:0] wline_w;

    // The screen starts a screen plus the scroll distance above the newest line.
    always_comb
    begin
        top_sum = tcs_pkg::TOTAL_W'(tcs_pkg::SCREEN_ROWS) + {1'b0, cur.vback};
        if (cur.total > top_sum)
        begin
            start_w = cur.total - top_sum;
        end
        else
        begin
            start_w = '0;
        end
        end_w   = start_w + tcs_pkg::TOTAL_W'(tcs_pkg::SCREEN_ROWS);
        wline_w = {1'b0, cur.wline};
        view.start = start_w[tcs_pkg::LINE_W-1:0];
        if (wline_w >= start_w && wline_w < end_w)
        begin
            view.crow = tcs_pkg::ROW_W'(wline_w - start_w);
            view.ccol = cur.wcol;
        end
        else
        begin
            view.crow = tcs_pkg::ROW_W'(tcs_pkg::SCREEN_ROWS - 1);
            view.ccol = '0;
        end
    end

endmodule

// File: rtl/text_console_scrollback.sv
// Top level of the text console scrollback engine.
`timescale 1ns / 1ps
// A beat on the slave side is applied as it is accepted, and its result is
// then presented from the output state, with the block not ready until the
// result beat leaves. A read of a visible cell passes through a read state
// for the registered memory read. A tab first writes its blank cells (up to
// 4) in the tab state, and any put char or clear that appends or clears a
// line first blanks that line cell by cell, since the single memory write
// port blanks one cell per cycle. After reset, line 0 is blanked in the same
// way, so the block accepts no beat until that sweep ends; configuration beats are taken at any time.
module text_console_scrollback (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: [7:0] text_color.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [12:8] view_row, [19:13] view_col, [23:20] zero.
    input  logic [23:0] s_tdata,
    // [2:0] operation.
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_col,
    // [37:28] viewport_offset, [38] scrolled_back, [49:39] stored_lines,
    // [55:50] zero.
    output logic [55:0] m_tdata
);

    localparam int LW = tcs_pkg::LINE_W;
    localparam int TW = tcs_pkg::TOTAL_W;
    localparam int CW = tcs_pkg::COL_W;

    tcs_pkg::state_t state_reg, state_next;
    logic [LW-1:0] base_reg, base_next;
    logic [TW-1:0] total_reg, total_next;
    logic [LW-1:0] wline_reg, wline_next;
    logic [CW-1:0] wcol_reg, wcol_next;
    logic [LW-1:0] vback_reg, vback_next;
    logic          locked_reg, locked_next;
    logic [7:0]    color_reg;
    logic [LW-1:0] blank_line_reg, blank_line_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic          init_reg, init_next;
    logic [CW-1:0] tab_stop_reg, tab_stop_next;
    logic [15:0]   cell_reg, cell_next;

    logic                      we;
    logic [tcs_pkg::ADDR_W-1:0] waddr;
    logic [15:0]               wdata;
    logic [tcs_pkg::ADDR_W-1:0] raddr;
    logic [15:0]               rdata;

    tcs_pkg::cursor_t cur;
    tcs_pkg::view_t   view;

    logic [7:0]    ch;
    logic [4:0]    vrow;
    logic [6:0]    vcol;
    logic          in_acc;
    logic [15:0]   blank_cell;
    logic [LW-1:0] cur_phys;
    logic [7:0]    tab_next;
    logic [TW-1:0] read_line;
    logic [TW-1:0] up_sum;
    logic [TW-1:0] max_top;
    logic          adv;
    logic          adv_view;

    assign ch         = s_tdata[7:0];
    assign vrow       = s_tdata[12:8];
    assign vcol       = s_tdata[19:13];
    assign in_acc     = s_tvalid && s_tready;
    assign blank_cell = {color_reg, tcs_pkg::CH_SPACE};
    assign cur_phys   = base_reg + wline_reg;
    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == tcs_pkg::ST_IDLE);
    assign m_tvalid   = (state_reg == tcs_pkg::ST_OUT);

    assign cur = '{total: total_reg, wline: wline_reg, wcol: wcol_reg, vback: vback_reg};

    tcs_view_calc u_view (
        .cur  (cur),
        .view (view)
    );

    tcs_cell_ram #(
        .ADDR_W (tcs_pkg::ADDR_W),
        .DATA_W (tcs_pkg::CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result beat.
    assign m_tdata = {6'd0, total_reg, (vback_reg != '0), vback_reg,
                      view.ccol, view.crow, cell_reg};

    // Attribute register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcs_pkg::COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_reg <= cfg_data;
        end
    end

    // Sequencer and console state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcs_pkg::ST_BLANK;
            base_reg       <= '0;
            total_reg      <= TW'(1);
            wline_reg      <= '0;
            wcol_reg       <= '0;
            vback_reg      <= '0;
            locked_reg     <= 1'b0;
            blank_line_reg <= '0;
            sweep_reg      <= '0;
            init_reg       <= 1'b1;
            tab_stop_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            total_reg      <= total_next;
            wline_reg      <= wline_next;
            wcol_reg       <= wcol_next;
            vback_reg      <= vback_next;
            locked_reg     <= locked_next;
            blank_line_reg <= blank_line_next;
            sweep_reg      <= sweep_next;
            init_reg       <= init_next;
            tab_stop_reg   <= tab_stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // Next state, memory port control and console updates.
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        total_next      = total_reg;
        wline_next      = wline_reg;
        wcol_next       = wcol_reg;
        vback_next      = vback_reg;
        locked_next     = locked_reg;
        blank_line_next = blank_line_reg;
        sweep_next      = sweep_reg;
        init_next       = init_reg;
        tab_stop_next   = tab_stop_reg;
        cell_next       = cell_reg;
        we              = 1'b0;
        waddr           = {cur_phys, wcol_reg};
        wdata           = blank_cell;
        adv             = 1'b0;
        adv_view        = 1'b0;
        tab_next        = ({1'b0, wcol_reg} + 8'(tcs_pkg::TAB_STOP)) & 8'hFC;
        read_line       = {1'b0, view.start} + TW'(vrow);
        raddr           = {base_reg + read_line[LW-1:0], vcol};
        up_sum          = {1'b0, vback_reg} + TW'(tcs_pkg::SCREEN_ROWS);
        max_top         = total_reg - TW'(tcs_pkg::SCREEN_ROWS);

        case (state_reg)
            tcs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = tcs_pkg::ST_OUT;
                    cell_next  = '0;
                    case (s_tuser)
                        tcs_pkg::OP_PUT:
                        begin
                            if (ch == tcs_pkg::CH_LF)
                            begin
                                adv      = 1'b1;
                                adv_view = 1'b1;
                            end
                            else if (ch == tcs_pkg::CH_CR)
                            begin
                                wcol_next = '0;
                            end
                            else if (ch == tcs_pkg::CH_BS)
                            begin
                                // Backspace wraps to the last column of the line above.
                                if (wcol_reg != '0)
                                begin
                                    wcol_next = wcol_reg - CW'(1);
                                    we        = 1'b1;
                                    waddr     = {cur_phys, wcol_reg - CW'(1)};
                                end
                                else if (wline_reg != '0)
                                begin
                                    wline_next = wline_reg - LW'(1);
                                    wcol_next  = CW'(tcs_pkg::SCREEN_COLS - 1);
                                    we         = 1'b1;
                                    waddr      = {cur_phys - LW'(1),
                                                  CW'(tcs_pkg::SCREEN_COLS - 1)};
                                end
                            end
                            else if (ch == tcs_pkg::CH_TAB)
                            begin
                                if (tab_next >= 8'(tcs_pkg::SCREEN_COLS))
                                begin
                                    adv      = 1'b1;
                                    adv_view = 1'b1;
                                end
                                else
                                begin
                                    tab_stop_next = tab_next[CW-1:0];
                                    state_next    = tcs_pkg::ST_TAB;
                                end
                            end
                            else if (ch >= tcs_pkg::CH_SPACE && ch <= tcs_pkg::CH_LAST)
                            begin
                                we    = 1'b1;
                                wdata = {color_reg, ch & tcs_pkg::CH_MASK};
                                if (wcol_reg == CW'(tcs_pkg::SCREEN_COLS - 1))
                                begin
                                    adv = 1'b1;
                                end
                                else
                                begin
                                    wcol_next = wcol_reg + CW'(1);
                                end
                            end
                        end
                        tcs_pkg::OP_PGUP:
                        begin
                            if (total_reg > TW'(tcs_pkg::SCREEN_ROWS))
                            begin
                                if (up_sum <= max_top)
                                begin
                                    vback_next = up_sum[LW-1:0];
                                end
                                else
                                begin
                                    vback_next = max_top[LW-1:0];
                                end
                                locked_next = (vback_next != '0);
                            end
                        end
                        tcs_pkg::OP_PGDN:
                        begin
                            if (vback_reg != '0)
                            begin
                                if (vback_reg > LW'(tcs_pkg::SCREEN_ROWS))
                                begin
                                    vback_next = vback_reg - LW'(tcs_pkg::SCREEN_ROWS);
                                end
                                else
                                begin
                                    vback_next = '0;
                                end
                                locked_next = (vback_next != '0);
                            end
                        end
                        tcs_pkg::OP_CLEAR:
                        begin
                            base_next       = '0;
                            total_next      = TW'(1);
                            wline_next      = '0;
                            wcol_next       = '0;
                            vback_next      = '0;
                            locked_next     = 1'b0;
                            blank_line_next = '0;
                            sweep_next      = '0;
                            state_next      = tcs_pkg::ST_BLANK;
                        end
                        tcs_pkg::OP_READ:
                        begin
                            cell_next = blank_cell;
                            if (vrow < 5'(tcs_pkg::SCREEN_ROWS)
                                && vcol < 7'(tcs_pkg::SCREEN_COLS)
                                && read_line < total_reg)
                            begin
                                state_next = tcs_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Move to the next line, appending and blanking one when needed.
                    if (adv)
                    begin
                        wcol_next = '0;
                        if (adv_view && !locked_reg)
                        begin
                            vback_next = '0;
                        end
                        if (({1'b0, wline_reg} + TW'(1)) >= total_reg)
                        begin
                            sweep_next = '0;
                            state_next = tcs_pkg::ST_BLANK;
                            if (total_reg < TW'(tcs_pkg::HISTORY_LINES))
                            begin
                                blank_line_next = base_reg + total_reg[LW-1:0];
                                total_next      = total_reg + TW'(1);
                                wline_next      = total_reg[LW-1:0];
                            end
                            else
                            begin
                                // Full: the oldest slot becomes the newest line.
                                base_next       = base_reg + LW'(1);
                                blank_line_next = base_reg;
                                wline_next      = LW'(tcs_pkg::HISTORY_LINES - 1);
                            end
                        end
                        else
                        begin
                            wline_next = wline_reg + LW'(1);
                        end
                    end
                end
            end
            tcs_pkg::ST_BLANK:
            begin
                // Blank one cell of the line per cycle.
                we         = 1'b1;
                waddr      = {blank_line_reg, sweep_reg};
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(tcs_pkg::SCREEN_COLS - 1))
                begin
                    sweep_next = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? tcs_pkg::ST_IDLE : tcs_pkg::ST_OUT;
                end
            end
            tcs_pkg::ST_TAB:
            begin
                // Fill blanks up to the tab stop.
                we        = 1'b1;
                wcol_next = wcol_reg + CW'(1);
                if (wcol_next == tab_stop_reg)
                begin
                    state_next = tcs_pkg::ST_OUT;
                end
            end
            tcs_pkg::ST_READ:
            begin
                cell_next  = rdata;
                state_next = tcs_pkg::ST_OUT;
            end
            tcs_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = tcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: test/tcs_checker.sv
// Checker for the text console scrollback block: predicts each result beat and compares it.
`timescale 1ns / 1ps
module tcs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  crow;
        logic [6:0]  ccol;
        logic [9:0]  offset;
        logic        back;
        logic [10:0] lines;
    } status_t;

    // Predicted console state.
    logic [15:0] screen_mem [0:tcs_pkg::HISTORY_LINES-1][0:tcs_pkg::SCREEN_COLS-1];
    int          base_slot;
    int          line_count;
    int          cur_line;
    int          cur_col;
    int          scroll_back;
    logic        view_locked;
    logic [7:0]  attr;
    status_t     expected_q[$];

    function automatic logic [15:0] cell_of(input logic [7:0] ch);
        return {attr, 1'b0, ch[6:0]};
    endfunction

    function automatic int slot_of(input int idx);
        return (base_slot + (idx % tcs_pkg::HISTORY_LINES)) % tcs_pkg::HISTORY_LINES;
    endfunction

    function automatic void blank_slot(input int slot);
        for (int x = 0; x < tcs_pkg::SCREEN_COLS; x++)
            screen_mem[slot][x] = cell_of(tcs_pkg::CH_SPACE);
    endfunction

    function automatic void add_line();
        if (line_count < tcs_pkg::HISTORY_LINES)
        begin
            blank_slot(slot_of(line_count));
            line_count++;
        end
        else
        begin
            base_slot = (base_slot + 1) % tcs_pkg::HISTORY_LINES;
            blank_slot(slot_of(tcs_pkg::HISTORY_LINES - 1));
        end
        if (cur_line >= line_count)
            cur_line = line_count - 1;
    endfunction

    function automatic void next_line();
        cur_col = 0;
        cur_line++;
        if (cur_line >= line_count)
            add_line();
    endfunction

    function automatic void line_feed();
        next_line();
        if (!view_locked)
            scroll_back = 0;
    endfunction

    function automatic void wipe_all();
        base_slot   = 0;
        line_count  = 1;
        cur_line    = 0;
        cur_col     = 0;
        scroll_back = 0;
        view_locked = 1'b0;
        blank_slot(0);
    endfunction

    function automatic int top_line();
        if (line_count > tcs_pkg::SCREEN_ROWS + scroll_back)
            return line_count - tcs_pkg::SCREEN_ROWS - scroll_back;
        return 0;
    endfunction

    function automatic void print_char(input logic [7:0] ch);
        int stop;
        if (ch == tcs_pkg::CH_LF)
            line_feed();
        else if (ch == tcs_pkg::CH_CR)
            cur_col = 0;
        else if (ch == tcs_pkg::CH_BS)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
                screen_mem[slot_of(cur_line)][cur_col] = cell_of(tcs_pkg::CH_SPACE);
            end
            else if (cur_line > 0)
            begin
                cur_line--;
                cur_col = tcs_pkg::SCREEN_COLS - 1;
                screen_mem[slot_of(cur_line)][cur_col] = cell_of(tcs_pkg::CH_SPACE);
            end
        end
        else if (ch == tcs_pkg::CH_TAB)
        begin
            stop = (cur_col + tcs_pkg::TAB_STOP) & ~(tcs_pkg::TAB_STOP - 1);
            if (stop >= tcs_pkg::SCREEN_COLS)
                line_feed();
            else
            begin
                while (cur_col < stop)
                begin
                    screen_mem[slot_of(cur_line)][cur_col] = cell_of(tcs_pkg::CH_SPACE);
                    cur_col++;
                end
            end
        end
        else if (ch >= tcs_pkg::CH_SPACE && ch <= tcs_pkg::CH_LAST)
        begin
            screen_mem[slot_of(cur_line)][cur_col] = cell_of(ch);
            cur_col++;
            if (cur_col >= tcs_pkg::SCREEN_COLS)
                next_line();
        end
    endfunction

    // Apply one input beat and return the status it leads to.
    function automatic status_t console_step(input logic [2:0] op, input logic [23:0] data);
        status_t    res;
        int         start;
        int         max_top;
        logic [4:0] row;
        logic [6:0] col;
        row = data[12:8];
        col = data[19:13];
        res = '0;
        case (op)
            tcs_pkg::OP_PUT: print_char(data[7:0]);
            tcs_pkg::OP_PGUP:
                if (line_count > tcs_pkg::SCREEN_ROWS)
                begin
                    max_top = line_count - tcs_pkg::SCREEN_ROWS;
                    if (scroll_back + tcs_pkg::SCREEN_ROWS <= max_top)
                        scroll_back += tcs_pkg::SCREEN_ROWS;
                    else
                        scroll_back = max_top;
                    view_locked = (scroll_back > 0);
                end
            tcs_pkg::OP_PGDN:
                if (scroll_back != 0)
                begin
                    if (scroll_back > tcs_pkg::SCREEN_ROWS)
                        scroll_back -= tcs_pkg::SCREEN_ROWS;
                    else
                        scroll_back = 0;
                    view_locked = (scroll_back > 0);
                end
            tcs_pkg::OP_CLEAR: wipe_all();
            tcs_pkg::OP_READ:
            begin
                start = top_line();
                res.cell_val = cell_of(tcs_pkg::CH_SPACE);
                if (row < tcs_pkg::SCREEN_ROWS && col < tcs_pkg::SCREEN_COLS
                    && start + row < line_count)
                    res.cell_val = screen_mem[slot_of(start + row)][col];
            end
            default: ;
        endcase
        start = top_line();
        if (cur_line >= start && cur_line < start + tcs_pkg::SCREEN_ROWS)
        begin
            res.crow = 5'(cur_line - start);
            res.ccol = 7'(cur_col);
        end
        else
        begin
            res.crow = 5'(tcs_pkg::SCREEN_ROWS - 1);
            res.ccol = '0;
        end
        res.offset = 10'(scroll_back);
        res.back   = (scroll_back > 0);
        res.lines  = 11'(line_count);
        return res;
    endfunction

    // Track configuration, input and result beats.
    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        status_t got;
        if (!rst_n)
        begin
            attr = tcs_pkg::COLOR_RESET;
            wipe_all();
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                attr = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(console_step(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[20:16], m_tdata[27:21], m_tdata[37:28],
                       m_tdata[38], m_tdata[49:39]};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want || m_tdata[55:50] !== 6'd0)
                    begin
                        $display("%0t: expected cell=%h row=%0d col=%0d off=%0d back=%0d n=%0d",
                                 $time, want.cell_val, want.crow, want.ccol, want.offset,
                                 want.back, want.lines);
                        $display("%0t: actual   cell=%h row=%0d col=%0d off=%0d back=%0d n=%0d",
                                 $time, got.cell_val, got.crow, got.ccol, got.offset,
                                 got.back, got.lines);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
// Top of the text console scrollback testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    int          fail_count;
    int          pending;
    logic        gaps_on = 1'b1;
    int          hold_req = 0;
    int          quiet_cycles = 0;

    text_console_scrollback dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tcs_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL text_console_scrollback");
            $finish;
        end
    end

    // Result side: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int wait_cycles;
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(negedge clk);
            while (!m_tvalid)
                @(negedge clk);
            @(posedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                wait_cycles = gaps_on ? $urandom_range(0, 16) : 0;
                if (wait_cycles > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_beat(input logic [2:0] op, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, col, row, ch};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Let every expected result arrive, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_color(input logic [7:0] color);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= color;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random beat; lf_pct steers how fast lines pile up.
    task automatic random_beat(input int lf_pct, input bit clear_ok);
        int          pick;
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [4:0]  row;
        logic [6:0]  col;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        row  = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 24));
        col  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 79));
        if (pick < lf_pct)
        begin
            op = tcs_pkg::OP_PUT;
            ch = tcs_pkg::CH_LF;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                op = tcs_pkg::OP_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    ch = 8'($urandom_range(tcs_pkg::CH_SPACE, tcs_pkg::CH_LAST));
                else if (pick < 70)
                    ch = tcs_pkg::CH_TAB;
                else if (pick < 80)
                    ch = tcs_pkg::CH_BS;
                else if (pick < 85)
                    ch = tcs_pkg::CH_CR;
            end
            else if (pick < 55)
                op = tcs_pkg::OP_PGUP;
            else if (pick < 65)
                op = tcs_pkg::OP_PGDN;
            else if (pick < 67)
                op = clear_ok ? tcs_pkg::OP_CLEAR : tcs_pkg::OP_READ;
            else if (pick < 97)
                op = tcs_pkg::OP_READ;
            else
                op = 3'($urandom_range(5, 7));
        end
        send_beat(op, ch, row, col);
    endtask

    task automatic random_run(input int count, input int lf_pct, input bit clear_ok,
                              input int hold_at);
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                gaps_on <= ($urandom_range(0, 3) != 0);
            if (n == hold_at)
                hold_req <= hold_req + 1;
            random_beat(lf_pct, clear_ok);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset color.
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd31, 7'd127);
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd24, 7'd79);
        send_beat(tcs_pkg::OP_PUT, 8'd65, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_LAST, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_SPACE, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, 8'd31, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, 8'd127, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, 8'd255, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_TAB, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_CR, 5'd0, 7'd0);
        // Backspace at the very first cell does nothing.
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_LF, 5'd0, 7'd0);
        // Backspace at column zero wraps to the previous line end.
        send_beat(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd0, 7'd79);
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd0, 7'd1);
        send_beat(tcs_pkg::OP_PGUP, 8'd0, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_PGDN, 8'd0, 5'd0, 7'd0);
        send_beat(3'd5, 8'd0, 5'd0, 7'd0);
        send_beat(3'd6, 8'd0, 5'd0, 7'd0);
        send_beat(3'd7, 8'd0, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_CLEAR, 8'd0, 5'd0, 7'd0);
        send_beat(tcs_pkg::OP_READ, 8'd0, 5'd0, 7'd0);

        // Mixed traffic with clears and one long result hold-off.
        write_color(8'h00);
        random_run(350, 10, 1'b1, 100);

        // Line-heavy traffic that fills the store and wraps the ring.
        write_color(8'hFF);
        random_run(1100, 80, 1'b0, -1);

        // Scrolling and reads over a full store.
        write_color(8'($urandom_range(0, 255)));
        random_run(480, 30, 1'b0, -1);

        drain();
        if (fail_count == 0)
            $display("PASS text_console_scrollback");
        else
            $display("FAIL text_console_scrollback");
        $finish;
    end

endmodule
